// ===== hw/rtl/cm5rgb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cm5rgb_pkg;

    localparam int CHAN_BITS = 8;
    localparam int FW_BITS = 11;
    localparam logic [FW_BITS-1:0] FW_RESET = 11'd1024;
    localparam logic [1:0] ROWS_FULL = 2'd2;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [CHAN_BITS-1:0] in_red;
        logic [CHAN_BITS-1:0] in_green;
        logic [CHAN_BITS-1:0] in_blue;
    } in_word_t;

    typedef struct packed {
        logic [CHAN_BITS-1:0] med_red;
        logic [CHAN_BITS-1:0] med_green;
        logic [CHAN_BITS-1:0] med_blue;
        logic                 frame_end;
    } out_word_t;

    typedef struct packed {
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
    } pixel_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cross_median5_rgb_filter_top.sv =====
// Output: a result is held in the stage-one registers, then in out_data_reg, after its word
// is accepted. Throughput: one word per cycle while in_stall is low; each line store does
// one read and one write per cycle, with right and two-rows-up reads issued ahead of use.
// Reset: rst_n clears column, row and flush counters, store select and pipeline valids,
// and sets frame_width to 1024. Line store contents are not cleared and need no sweep.
`timescale 1ns / 1ps
`default_nettype none

module cross_median5_rgb_filter_top
    import cm5rgb_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [FW_BITS-1:0]   cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire in_word_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_word_t                 out_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = (AW + 1 > FW_BITS) ? AW + 1 : FW_BITS;
    localparam logic [CW-1:0] MAXW = CW'(MAX_WIDTH);

    function automatic logic [AW-1:0] last_col(input logic [FW_BITS-1:0] fw);
        logic [CW-1:0] fx;
        logic [CW-1:0] w;
        fx = CW'(fw);
        if (fx == '0)
            w = CW'(1);
        else if (fx > MAXW)
            w = MAXW;
        else
            w = fx;
        return AW'(w - CW'(1));
    endfunction

    function automatic logic [AW-1:0] right_col(input logic [AW-1:0] x,
                                                input logic [AW-1:0] wl);
        return (x < wl) ? x + AW'(1) : wl;
    endfunction

    function automatic logic [CHAN_BITS-1:0] med5(input logic [CHAN_BITS-1:0] a,
                                                  input logic [CHAN_BITS-1:0] b,
                                                  input logic [CHAN_BITS-1:0] c,
                                                  input logic [CHAN_BITS-1:0] d,
                                                  input logic [CHAN_BITS-1:0] e);
        logic [CHAN_BITS-1:0] min_ab, max_ab, min_cd, max_cd, f, g, lo, hi;
        min_ab = (a < b) ? a : b;
        max_ab = (a < b) ? b : a;
        min_cd = (c < d) ? c : d;
        max_cd = (c < d) ? d : c;
        f = (min_ab > min_cd) ? min_ab : min_cd;
        g = (max_ab < max_cd) ? max_ab : max_cd;
        lo = (f < g) ? f : g;
        hi = (f < g) ? g : f;
        if (e < lo)
            return lo;
        else if (e > hi)
            return hi;
        else
            return e;
    endfunction

    function automatic pixel_t med_px(input pixel_t a, input pixel_t b, input pixel_t c,
                                      input pixel_t d, input pixel_t e);
        pixel_t m;
        m.red   = med5(a.red, b.red, c.red, d.red, e.red);
        m.green = med5(a.green, b.green, c.green, d.green, e.green);
        m.blue  = med5(a.blue, b.blue, c.blue, d.blue, e.blue);
        return m;
    endfunction

    // control state
    logic [FW_BITS-1:0] frame_width_reg, frame_width_next;
    logic               usel_reg, usel_next;
    logic [AW-1:0]      column_count_reg, column_count_next;
    logic [1:0]         rows_seen_reg, rows_seen_next;
    logic [AW-1:0]      flush_count_reg, flush_count_next;

    // window over the upper row: left and centre of the current column
    pixel_t upl_reg, upl_next;
    pixel_t upc_reg, upc_next;
    pixel_t first_px_reg;

    // line stores
    pixel_t        row_store_a [MAX_WIDTH];
    pixel_t        row_store_b [MAX_WIDTH];
    pixel_t        q_a_reg, q_b_reg;
    logic          byp_a_reg, byp_b_reg;
    pixel_t        byp_data_reg;
    logic [AW-1:0] raddr_a, raddr_b;
    logic          we_a, we_b;
    pixel_t        a_eff, b_eff, rd_up, rd_old;

    // pipeline
    logic   s1_valid_reg;
    pixel_t s1_c_reg, s1_l_reg, s1_r_reg, s1_u_reg, s1_d_reg;
    logic   s1_end_reg;
    logic   out_valid_reg;
    out_word_t out_data_reg;
    logic   out_adv;

    logic          in_acc, is_flush, pix_take, flush_take, produce, at_last, end_now;
    logic [AW-1:0] x, wlast_cur, wlast_nxt, pos_nxt, rx_nxt;
    pixel_t        px, op_u, op_d, pix_center_next;

    assign out_adv  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !out_adv;
    assign in_acc   = in_valid && !in_stall;

    assign px.red   = in_data.in_red;
    assign px.green = in_data.in_green;
    assign px.blue  = in_data.in_blue;

    assign is_flush   = (in_data.op == OP_FLUSH);
    assign pix_take   = in_acc && !is_flush && (flush_count_reg == '0);
    assign flush_take = in_acc && is_flush && (column_count_reg == '0)
                        && (rows_seen_reg != 2'd0);
    assign x          = is_flush ? flush_count_reg : column_count_reg;
    assign wlast_cur  = last_col(frame_width_reg);
    assign at_last    = (x >= wlast_cur);
    assign produce    = (pix_take && (rows_seen_reg != 2'd0)) || flush_take;
    assign end_now    = flush_take && at_last;

    // bypass a read that met a write to the same entry at the same edge
    assign a_eff  = byp_a_reg ? byp_data_reg : q_a_reg;
    assign b_eff  = byp_b_reg ? byp_data_reg : q_b_reg;
    assign rd_up  = usel_reg ? b_eff : a_eff;
    assign rd_old = usel_reg ? a_eff : b_eff;

    assign op_u = (rows_seen_reg >= ROWS_FULL) ? rd_old : upc_reg;
    assign op_d = is_flush ? upc_reg : px;
    assign pix_center_next = (x == '0) ? px : first_px_reg;

    always_comb
    begin
        frame_width_next  = cfg_we ? cfg_data : frame_width_reg;
        usel_next         = usel_reg;
        column_count_next = column_count_reg;
        rows_seen_next    = rows_seen_reg;
        flush_count_next  = flush_count_reg;
        upl_next          = upl_reg;
        upc_next          = upc_reg;
        if (pix_take)
        begin
            if (at_last)
            begin
                column_count_next = '0;
                usel_next         = !usel_reg;
                if (rows_seen_reg < ROWS_FULL)
                    rows_seen_next = rows_seen_reg + 2'd1;
                // the row just written becomes the upper row: prime at column 0
                upl_next = pix_center_next;
                upc_next = pix_center_next;
            end
            else
            begin
                column_count_next = x + AW'(1);
                upl_next          = upc_reg;
                upc_next          = rd_up;
            end
        end
        else if (flush_take)
        begin
            upl_next = upc_reg;
            upc_next = rd_up;
            if (at_last)
            begin
                flush_count_next  = '0;
                rows_seen_next    = 2'd0;
                column_count_next = '0;
            end
            else
                flush_count_next = x + AW'(1);
        end
    end

    // issue reads for the column the next word will see
    assign wlast_nxt = last_col(frame_width_next);
    assign pos_nxt   = (flush_count_next != '0) ? flush_count_next : column_count_next;
    assign rx_nxt    = right_col(pos_nxt, wlast_nxt);
    assign raddr_a   = usel_next ? pos_nxt : rx_nxt;
    assign raddr_b   = usel_next ? rx_nxt : pos_nxt;
    assign we_a      = pix_take && usel_reg;
    assign we_b      = pix_take && !usel_reg;

    always_ff @(posedge clk)
    begin
        if (we_a)
            row_store_a[column_count_reg] <= px;
        q_a_reg <= row_store_a[raddr_a];
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
            row_store_b[column_count_reg] <= px;
        q_b_reg <= row_store_b[raddr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FW_RESET;
            usel_reg         <= 1'b0;
            column_count_reg <= '0;
            rows_seen_reg    <= 2'd0;
            flush_count_reg  <= '0;
            byp_a_reg        <= 1'b0;
            byp_b_reg        <= 1'b0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            usel_reg         <= usel_next;
            column_count_reg <= column_count_next;
            rows_seen_reg    <= rows_seen_next;
            flush_count_reg  <= flush_count_next;
            byp_a_reg        <= we_a && (column_count_reg == raddr_a);
            byp_b_reg        <= we_b && (column_count_reg == raddr_b);
            if (!in_stall)
                s1_valid_reg <= in_acc && produce;
            if (out_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        upl_reg      <= upl_next;
        upc_reg      <= upc_next;
        byp_data_reg <= px;
        if (pix_take && (column_count_reg == '0))
            first_px_reg <= px;
        if (!in_stall)
        begin
            s1_c_reg   <= upc_reg;
            s1_l_reg   <= upl_reg;
            s1_r_reg   <= rd_up;
            s1_u_reg   <= op_u;
            s1_d_reg   <= op_d;
            s1_end_reg <= end_now;
        end
        if (out_adv)
        begin
            {out_data_reg.med_red, out_data_reg.med_green, out_data_reg.med_blue} <=
                med_px(s1_c_reg, s1_l_reg, s1_r_reg, s1_u_reg, s1_d_reg);
            out_data_reg.frame_end <= s1_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_count_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !((column_count_reg != '0) && (flush_count_reg != '0)))
        else $error("column and flush counters both active");

    a_rows_sat: assert property (@(posedge clk) disable iff (!rst_n)
        rows_seen_reg <= ROWS_FULL)
        else $error("rows_seen beyond saturation");

    a_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
        end_now |=> (rows_seen_reg == 2'd0) && (flush_count_reg == '0)
                    && (column_count_reg == '0))
        else $error("frame end did not return counters to zero");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && in_stall) |=> s1_valid_reg)
        else $error("stage-one word dropped while stalled");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        (we_a || we_b) |-> (flush_count_reg == '0) && !(we_a && we_b))
        else $error("line store write during flush or to both stores");

endmodule

`default_nettype wire
